// ===== hdl/esk_pkg.sv =====
package esk_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 9;
  localparam int unsigned MaxRun  = 5;
  localparam int unsigned RunCntW = 3;
  localparam int unsigned HeldN   = 4;
  localparam int unsigned HeldCntW = 3;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  localparam logic [ByteW-1:0] EscByte   = 8'h1b;
  localparam logic [ByteW-1:0] CsiByte   = 8'h5b;
  localparam logic [ByteW-1:0] Ss3Byte   = 8'h4f;
  localparam logic [ByteW-1:0] TildeByte = 8'h7e;
  localparam logic [ByteW-1:0] CrByte    = 8'h0d;
  localparam logic [ByteW-1:0] LfByte    = 8'h0a;
  localparam logic [CodeW-1:0] FkeyBase  = 9'h100;

  localparam logic [23:0] PreF5 = 24'h315b1b;
  localparam logic [23:0] PreF9 = 24'h325b1b;
  localparam logic [23:0] PreFb = 24'h4f5b1b;

  localparam logic [23:0] ShortTab [4] = '{24'h504f1b, 24'h514f1b, 24'h524f1b, 24'h534f1b};

  localparam logic [31:0] TildeTab [8] = '{
    32'h35315b1b, 32'h37315b1b, 32'h38315b1b, 32'h39315b1b,
    32'h30325b1b, 32'h31325b1b, 32'h33325b1b, 32'h34325b1b
  };

  localparam logic [31:0] FbTab [12] = '{
    32'h504f5b1b, 32'h514f5b1b, 32'h524f5b1b, 32'h534f5b1b,
    32'h35315b1b, 32'h37315b1b, 32'h38315b1b, 32'h39315b1b,
    32'h38325b1b, 32'h39325b1b, 32'h33325b1b, 32'h34325b1b
  };

  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    logic [RunCntW-1:0]     cnt;
    code_t [MaxRun-1:0]     codes;
  } run_t;

  function automatic logic [3:0] find_short(logic [23:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 4; i++) begin
      if (ShortTab[i] == v) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [3:0] find_tilde(logic [31:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (TildeTab[i] == v) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [3:0] find_fb(logic [31:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 12; i++) begin
      if (FbTab[i] == v) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic code_t fkey_code(logic [3:0] k);
    return FkeyBase | {{(CodeW-4){1'b0}}, k};
  endfunction

endpackage

// ===== hdl/esk_front.sv =====
module esk_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [7:0]            scan_byte_i,
  output logic                  run_valid_o,
  output esk_pkg::run_t         run_o
);
  import esk_pkg::*;

  logic                      mode_q;
  logic [ByteW-1:0]          held_q [HeldN];
  logic [ByteW-1:0]          held_d [HeldN];
  logic [HeldCntW-1:0]       cnt_q, cnt_d;

  logic [ByteW-1:0]          b;
  logic [ByteW-1:0]          nb [HeldN];
  logic [31:0]               v;
  logic [31:0]               held_v;
  logic                      hold, fk;
  logic [3:0]                k;
  code_t                     fk_code;
  run_t                      run;

  always_comb begin
    b = (scan_byte_i == CrByte) ? LfByte : scan_byte_i;
    for (int i = 0; i < HeldN; i++) begin
      if (HeldCntW'(i) < cnt_q) nb[i] = held_q[i];
      else if (HeldCntW'(i) == cnt_q) nb[i] = b;
      else nb[i] = '0;
    end
    v      = {nb[3], nb[2], nb[1], nb[0]};
    held_v = {held_q[3], held_q[2], held_q[1], held_q[0]};
  end

  always_comb begin
    hold    = 1'b0;
    fk      = 1'b0;
    k       = '0;
    fk_code = '0;
    if (!mode_q && b == TildeByte) begin
      k = find_tilde(held_v);
      if (cnt_q == HeldCntW'(HeldN) && k != '0) begin
        fk      = 1'b1;
        fk_code = fkey_code(k + 4'd4);
      end
    end else if (cnt_q == HeldCntW'(HeldN) || nb[0] != EscByte) begin
      hold = 1'b0;
    end else if (cnt_q == 3'd0) begin
      hold = 1'b1;
    end else if (mode_q ? (nb[1] != CsiByte) : (nb[1] != Ss3Byte && nb[1] != CsiByte)) begin
      hold = 1'b0;
    end else if (cnt_q == 3'd1) begin
      hold = 1'b1;
    end else if (!mode_q && cnt_q == 3'd2 && find_short(v[23:0]) != '0) begin
      fk      = 1'b1;
      fk_code = fkey_code(find_short(v[23:0]));
    end else if (!(v[23:0] == PreF5 || v[23:0] == PreF9 || (mode_q && v[23:0] == PreFb))) begin
      hold = 1'b0;
    end else if (cnt_q == 3'd2) begin
      hold = 1'b1;
    end else if (!mode_q) begin
      hold = (find_tilde(v) != '0);
    end else begin
      k = find_fb(v);
      if (k != '0) begin
        fk      = 1'b1;
        fk_code = fkey_code(k);
      end
    end
  end

  // flush run: a single function-key code, or held bytes in order, then the current byte
  always_comb begin
    run = '0;
    if (fk) begin
      run.cnt      = RunCntW'(1);
      run.codes[0] = fk_code;
    end else if (!hold) begin
      run.cnt = cnt_q + 3'd1;
      for (int i = 0; i < MaxRun; i++) begin
        if (i < HeldN && HeldCntW'(i) < cnt_q) run.codes[i] = {1'b0, held_q[i]};
        else run.codes[i] = {1'b0, b};
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < HeldN; i++) held_d[i] = held_q[i];
    if (accept_i) begin
      if (hold) begin
        cnt_d = cnt_q + 3'd1;
        for (int i = 0; i < HeldN; i++) held_d[i] = nb[i];
      end else begin
        cnt_d = '0;
        for (int i = 0; i < HeldN; i++) held_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cnt_q  <= '0;
      for (int i = 0; i < HeldN; i++) held_q[i] <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
      for (int i = 0; i < HeldN; i++) held_q[i] <= held_d[i];
    end
  end

  assign run_valid_o = accept_i && !hold;
  assign run_o       = run;

endmodule

// ===== hdl/esk_queue.sv =====
module esk_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  esk_pkg::run_t         wr_data_i,
  output logic                  full_o,
  input  logic                  rd_i,
  output logic                  empty_o,
  output esk_pkg::run_t         rd_data_o
);
  import esk_pkg::*;

  run_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_wr, do_rd;

  always_comb begin
    do_wr = wr_i && !full_o;
    do_rd = rd_i && !empty_o;
    wp_d  = do_wr ? wp_q + QPtrW'(1) : wp_q;
    rp_d  = do_rd ? rp_q + QPtrW'(1) : rp_q;
    cnt_d = cnt_q + QCntW'(do_wr) - QCntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];

endmodule

// ===== hdl/esk_back.sv =====
module esk_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  esk_pkg::run_t         q_head_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [8:0]            key_code_o,
  output logic                  last_of_run_o
);
  import esk_pkg::*;

  logic [RunCntW-1:0] idx_q, idx_d;
  logic               ov_q, ov_d;
  code_t              key_q, key_d;
  logic               last_q, last_d;
  logic               load, is_last;

  always_comb begin
    load    = !q_empty_i && (!ov_q || pop_i);
    is_last = (idx_q == q_head_i.cnt - RunCntW'(1));
    idx_d   = idx_q;
    ov_d    = ov_q && !pop_i;
    key_d   = key_q;
    last_d  = last_q;
    if (load) begin
      ov_d   = 1'b1;
      key_d  = q_head_i.codes[idx_q];
      last_d = is_last;
      idx_d  = is_last ? '0 : idx_q + RunCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    last_q <= last_d;
  end

  assign q_pop_o       = load && is_last;
  assign empty_o       = !ov_q;
  assign key_code_o    = key_q;
  assign last_of_run_o = last_q;

endmodule

// ===== hdl/escape_sequence_key_decoder.sv =====
// Channel   Handshake                  Beat
// input     push / full                scan_byte_i
// result    empty / pop                key_code_o, last_of_run_o
// config    cfg_we_i                   cfg_wdata_i (framebuffer mode)
//
// One byte accepted per cycle while the two-run queue has room.
// A byte yields a run of zero to five codes; the back end sends one code per cycle
// while the result side keeps popping.
// Reset clears held bytes and selects the tilde-terminated table.
// A stalled result side fills the queue and then raises full.
module escape_sequence_key_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] scan_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [8:0] key_code_o,
  output logic       last_of_run_o
);
  import esk_pkg::*;

  logic  accept, run_valid, q_empty, q_pop;
  run_t  run, q_head;

  assign accept = push && !full;

  esk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .scan_byte_i (scan_byte_i),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  esk_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (run_valid),
    .wr_data_i (run),
    .full_o    (full),
    .rd_i      (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (q_head)
  );

  esk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .key_code_o    (key_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
